// File: src/bsfb_pkg.sv
// Shared types, constants and helpers for the byte-stuffed frame builder.
package bsfb_pkg;

  localparam int unsigned DataW         = 8;
  localparam int unsigned MaxPayloadDef = 30;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [DataW-1:0] HeaderRst = 8'd237;
  localparam logic [DataW-1:0] FooterRst = 8'd238;
  localparam logic [DataW-1:0] EscapeRst = 8'd233;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_HEADER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 2'd2;

  // which source feeds the output register
  typedef enum logic [2:0] {
    OSEL_HDR,
    OSEL_LEN,
    OSEL_ESC,
    OSEL_PAY,
    OSEL_CHK,
    OSEL_FTR
  } osel_e;

  typedef struct packed {
    logic  in_ready;
    logic  load;
    osel_e osel;
    logic  ptr_clr;
    logic  ptr_inc;
    logic  msg_clr;
  } cmd_t;

  typedef struct packed {
    logic take_final;
    logic out_free;
    logic ptr_at_end;
    logic cur_special;
  } status_t;

  function automatic logic is_special(input logic [DataW-1:0] b,
                                      input logic [DataW-1:0] hdr,
                                      input logic [DataW-1:0] ftr,
                                      input logic [DataW-1:0] esc);
    return (b == hdr) || (b == ftr) || (b == esc);
  endfunction

endpackage

// File: src/bsfb_intf.sv
// Handshake channel interfaces for payload items and frame items.
interface bsfb_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsfb_pkg::DataW-1:0]    payload_byte;
  logic                          final_byte;

  modport source (output valid, output payload_byte, output final_byte, input ready);
  modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface bsfb_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsfb_pkg::DataW-1:0]    frame_byte;
  logic                          frame_end;
  logic                          overflowed;

  modport source (output valid, output frame_byte, output frame_end, output overflowed,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_end, input overflowed,
                  output ready);
endinterface

// File: src/bsfb_ctrl.sv
// Frame sequencer: walks header, length, escaped payload, checksum, footer.
module bsfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsfb_pkg::status_t st_i,
  output bsfb_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_LEN,
    S_PAY,
    S_CHK,
    S_FTR
  } state_e;

  state_e state_q, state_d;
  logic   esc_sent_q, esc_sent_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.osel     = bsfb_pkg::OSEL_HDR;
    cmd_o.in_ready = (state_q == S_IDLE);
    state_d        = state_q;
    esc_sent_d     = esc_sent_q;
    unique case (state_q)
      S_IDLE: begin
        if (st_i.take_final) state_d = S_HDR;
      end
      S_HDR: begin
        if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.osel = bsfb_pkg::OSEL_HDR;
          state_d    = S_LEN;
        end
      end
      S_LEN: begin
        if (st_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.osel    = bsfb_pkg::OSEL_LEN;
          cmd_o.ptr_clr = 1'b1;
          esc_sent_d    = 1'b0;
          state_d       = S_PAY;
        end
      end
      S_PAY: begin
        if (st_i.ptr_at_end) begin
          state_d = S_CHK;
        end else if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          if (st_i.cur_special && !esc_sent_q) begin
            cmd_o.osel = bsfb_pkg::OSEL_ESC;
            esc_sent_d = 1'b1;
          end else begin
            cmd_o.osel    = bsfb_pkg::OSEL_PAY;
            cmd_o.ptr_inc = 1'b1;
            esc_sent_d    = 1'b0;
          end
        end
      end
      S_CHK: begin
        if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.osel = bsfb_pkg::OSEL_CHK;
          state_d    = S_FTR;
        end
      end
      S_FTR: begin
        if (st_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.osel    = bsfb_pkg::OSEL_FTR;
          cmd_o.msg_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      esc_sent_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      esc_sent_q <= esc_sent_d;
    end
  end

endmodule

// File: src/bsfb_datapath.sv
// Config registers, payload store, counters, checksum and output register.
module bsfb_datapath #(
  parameter int unsigned MaxPayload = bsfb_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsfb_pkg::DataW-1:0]    cfg_data_i,
  input  bsfb_pkg::cmd_t                cmd_i,
  output bsfb_pkg::status_t             st_o,
  bsfb_in_if.sink                       in_ch_i,
  bsfb_out_if.source                    out_ch_o
);

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPayload);

  logic [bsfb_pkg::DataW-1:0] hdr_q, ftr_q, esc_q;
  logic [bsfb_pkg::DataW-1:0] store_q [MaxPayload];
  logic [CntW-1:0]            cnt_q, esc_cnt_q, ptr_q;
  logic [bsfb_pkg::DataW-1:0] sum_q;
  logic                       ovf_q;

  logic                       out_valid_q;
  logic [bsfb_pkg::DataW-1:0] out_byte_q;
  logic                       out_end_q, out_ovf_q;

  logic                       in_fire, in_special, room;
  logic [bsfb_pkg::DataW-1:0] rd_byte, out_byte_d, sum_add;

  assign in_ch_i.ready = cmd_i.in_ready;
  assign in_fire       = in_ch_i.valid && cmd_i.in_ready;
  assign room          = (cnt_q != CntMax);
  assign in_special    = bsfb_pkg::is_special(in_ch_i.payload_byte, hdr_q, ftr_q, esc_q);
  assign sum_add       = in_special ? esc_q : '0;
  assign rd_byte       = store_q[ptr_q[IdxW-1:0]];

  assign st_o.take_final  = in_fire && in_ch_i.final_byte;
  assign st_o.out_free    = !out_valid_q || out_ch_o.ready;
  assign st_o.ptr_at_end  = (ptr_q == cnt_q);
  assign st_o.cur_special = bsfb_pkg::is_special(rd_byte, hdr_q, ftr_q, esc_q);

  always_comb begin
    case (cmd_i.osel)
      bsfb_pkg::OSEL_HDR: out_byte_d = hdr_q;
      bsfb_pkg::OSEL_LEN: out_byte_d = bsfb_pkg::DataW'(cnt_q) + bsfb_pkg::DataW'(esc_cnt_q);
      bsfb_pkg::OSEL_ESC: out_byte_d = esc_q;
      bsfb_pkg::OSEL_PAY: out_byte_d = rd_byte;
      bsfb_pkg::OSEL_CHK: out_byte_d = sum_q;
      bsfb_pkg::OSEL_FTR: out_byte_d = ftr_q;
      default:            out_byte_d = ftr_q;
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= bsfb_pkg::HeaderRst;
      ftr_q <= bsfb_pkg::FooterRst;
      esc_q <= bsfb_pkg::EscapeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsfb_pkg::CFG_HEADER: hdr_q <= cfg_data_i;
        bsfb_pkg::CFG_FOOTER: ftr_q <= cfg_data_i;
        bsfb_pkg::CFG_ESCAPE: esc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      esc_cnt_q <= '0;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
      ptr_q     <= '0;
    end else begin
      if (cmd_i.msg_clr) begin
        cnt_q     <= '0;
        esc_cnt_q <= '0;
        sum_q     <= '0;
        ovf_q     <= 1'b0;
      end else if (in_fire) begin
        if (room) begin
          cnt_q <= cnt_q + 1'b1;
          if (in_special) esc_cnt_q <= esc_cnt_q + 1'b1;
          sum_q <= sum_q + sum_add + in_ch_i.payload_byte;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.ptr_clr) ptr_q <= '0;
      else if (cmd_i.ptr_inc) ptr_q <= ptr_q + 1'b1;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && room) store_q[cnt_q[IdxW-1:0]] <= in_ch_i.payload_byte;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= (cmd_i.osel == bsfb_pkg::OSEL_FTR);
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.frame_byte = out_byte_q;
  assign out_ch_o.frame_end  = out_end_q;
  assign out_ch_o.overflowed = out_ovf_q;

endmodule

// File: src/byte_stuffed_frame_builder_top.sv
// Top level of the byte-stuffed frame builder: sequencer plus datapath.
//
// Payload bytes come in as items on in_ch_i; each is stored (up to MaxPayload
// bytes) while the escaped length and an 8-bit additive checksum over the
// escaped stream are kept up to date. Non-final items are taken while idle,
// and such items may arrive back to back. The item marked final_byte closes
// the message: ready drops and the block sends header, escaped length,
// escaped payload (escape byte ahead of any header/footer/escape value),
// checksum and footer through a single output register, one item per cycle
// while the sink does not stall, with a pause before the header and another
// after the last payload byte; ready comes back the cycle after the footer is
// loaded. The footer has frame_end set; overflowed is set on every byte of a
// frame that lost bytes past capacity. The escape test on emission uses the
// register values at that time. Config registers (0 header, 1 footer,
// 2 escape) are written with cfg_we_i; other indexes are ignored.
module byte_stuffed_frame_builder_top #(
  parameter int unsigned MaxPayload = bsfb_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsfb_pkg::DataW-1:0]    cfg_data_i,
  bsfb_in_if.sink                       in_ch_i,
  bsfb_out_if.source                    out_ch_o
);

  bsfb_pkg::cmd_t    cmd;
  bsfb_pkg::status_t st;

  bsfb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  bsfb_datapath #(
    .MaxPayload (MaxPayload)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_ch_i    (in_ch_i),
    .out_ch_o   (out_ch_o)
  );

  // output register is only loaded when it is empty or being drained
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> st.out_free)
    else $error("output register overwritten while holding an item");

  // message state clears exactly with the footer load
  a_clr_footer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.msg_clr |-> (cmd.load && cmd.osel == bsfb_pkg::OSEL_FTR))
    else $error("message state cleared outside footer load");

  // read pointer advances only when a payload byte is sent
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ptr_inc |-> (cmd.load && cmd.osel == bsfb_pkg::OSEL_PAY && !st.ptr_at_end))
    else $error("payload pointer advanced without a payload byte");

  // no input is taken while a frame is being sent
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_ch_i.ready)
    else $error("input ready during frame emission");

endmodule

// File: bench/bsfb_frame_checker.sv
// Frame checker: mirrors registers and message state, predicts frame items, compares.
`timescale 1ns / 100ps
module bsfb_frame_checker #(
  parameter int unsigned MaxPayload = bsfb_pkg::MaxPayloadDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsfb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bsfb_pkg::DataW-1:0]   cfg_data_i,
  bsfb_in_if                           in_ch_i,
  bsfb_out_if                          out_ch_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           frames_o,
  output int                           checked_o
);

  typedef logic [bsfb_pkg::DataW-1:0] octet_t;
  typedef struct packed {
    octet_t data;
    logic   last;
    logic   lost;
  } frame_item_t;

  octet_t      hdr_r, ftr_r, esc_r;
  octet_t      msg_buf [MaxPayload];
  int unsigned msg_len, stuff_cnt;
  octet_t      chk_sum;
  logic        lost_r;
  frame_item_t frame_q [$];
  int          fails, frames, checked;

  function automatic logic needs_escape(input octet_t b);
    return (b == hdr_r) || (b == ftr_r) || (b == esc_r);
  endfunction

  task automatic push_frame_item(input octet_t b, input logic last);
    frame_q.push_back('{data: b, last: last, lost: lost_r});
  endtask

  // Counts and sum use the registers at arrival, the emitted escapes use them at the final item.
  task automatic take_payload(input octet_t b, input logic fin);
    int i;
    if (msg_len < MaxPayload) begin
      msg_buf[msg_len] = b;
      msg_len++;
      if (needs_escape(b)) begin
        stuff_cnt++;
        chk_sum += esc_r;
      end
      chk_sum += b;
    end else begin
      lost_r = 1'b1;
    end
    if (fin) begin
      push_frame_item(hdr_r, 1'b0);
      push_frame_item(octet_t'(msg_len + stuff_cnt), 1'b0);
      for (i = 0; i < msg_len; i++) begin
        if (needs_escape(msg_buf[i])) push_frame_item(esc_r, 1'b0);
        push_frame_item(msg_buf[i], 1'b0);
      end
      push_frame_item(chk_sum, 1'b0);
      push_frame_item(ftr_r, 1'b1);
      msg_len   = 0;
      stuff_cnt = 0;
      chk_sum   = '0;
      lost_r    = 1'b0;
      frames++;
    end
  endtask

  task automatic check_frame_item(input octet_t b, input logic last, input logic lost);
    frame_item_t want;
    checked++;
    if (frame_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected frame item %02h (end %0b, overflowed %0b), nothing pending",
                 b, last, lost);
    end else begin
      want = frame_q.pop_front();
      if (want.data !== b || want.last !== last || want.lost !== lost) begin
        fails++;
        if (fails <= 10)
          $display("frame item %0d: expected %02h end %0b ovf %0b, got %02h end %0b ovf %0b",
                   checked, want.data, want.last, want.lost, b, last, lost);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_r     = bsfb_pkg::HeaderRst;
      ftr_r     = bsfb_pkg::FooterRst;
      esc_r     = bsfb_pkg::EscapeRst;
      msg_len   = 0;
      stuff_cnt = 0;
      chk_sum   = '0;
      lost_r    = 1'b0;
      frame_q.delete();
      fails     = 0;
      frames    = 0;
      checked   = 0;
    end else begin
      if (out_ch_i.valid && out_ch_i.ready)
        check_frame_item(out_ch_i.frame_byte, out_ch_i.frame_end, out_ch_i.overflowed);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsfb_pkg::CFG_HEADER: hdr_r = cfg_data_i;
          bsfb_pkg::CFG_FOOTER: ftr_r = cfg_data_i;
          bsfb_pkg::CFG_ESCAPE: esc_r = cfg_data_i;
          default: ;
        endcase
      end
      if (in_ch_i.valid && in_ch_i.ready)
        take_payload(in_ch_i.payload_byte, in_ch_i.final_byte);
    end
    fail_count_o <= fails;
    pending_o    <= frame_q.size();
    frames_o     <= frames;
    checked_o    <= checked;
  end

endmodule

// File: bench/byte_stuffed_frame_builder_top_test.sv
// Bench top for the byte-stuffed frame builder: clock, reset, stimulus, sink stalls, verdict.
`timescale 1ns / 100ps
module byte_stuffed_frame_builder_top_test;

  typedef logic [bsfb_pkg::DataW-1:0] octet_t;

  // index 3 has no register behind it; writes there must be ignored
  localparam logic [bsfb_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // no-progress limit: far above the longest sink stall plus sender gap plus a
  // settle pause; a full 64-item frame alone never stops progress that long
  localparam int unsigned StallLimit  = 1000;
  // idle cycles after the last frame item, before touching registers or ending
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBudget = 16;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_BURSTY
  } sink_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [bsfb_pkg::CfgIdxW-1:0]  cfg_idx;
  octet_t                        cfg_data;

  bsfb_in_if  in_ch ();
  bsfb_out_if out_ch ();

  int         fail_count, pending, frames, checked;
  octet_t     cur_hdr, cur_ftr, cur_esc;
  bit         pace_on;
  int         burst_left;
  int         items_sent, msgs_sent, long_msgs;
  int         idle_cycles = 0;
  logic [8:0] sink_tick;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_stuffed_frame_builder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // Predicts every frame item from the accepted payload items and compares.
  bsfb_frame_checker frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frames_o     (frames),
    .checked_o    (checked)
  );

  // Sink back-pressure: the mode rotates with bits 8:7 of sink_tick, so stalls land on
  // header, length, payload, checksum and footer alike; the open mode gives
  // long stretches with no stall at all.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_tick    <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      sink_tick <= sink_tick + 1'b1;
      case (sink_mode_e'(sink_tick[8:7]))
        SINK_OPEN:     out_ch.ready <= 1'b1;
        SINK_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: out_ch.ready <= (sink_tick[2:0] > 3'd2);
        default:       out_ch.ready <= (sink_tick[4:0] < 5'd20);
      endcase
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One register write per cycle; the caller drops the write enable after a
  // group so it is never lowered and raised in the same step.
  task automatic write_reg(input logic [bsfb_pkg::CfgIdxW-1:0] idx, input octet_t val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      bsfb_pkg::CFG_HEADER: cur_hdr = val;
      bsfb_pkg::CFG_FOOTER: cur_ftr = val;
      bsfb_pkg::CFG_ESCAPE: cur_esc = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input octet_t hdr, input octet_t ftr, input octet_t esc);
    write_reg(bsfb_pkg::CFG_HEADER, hdr);
    write_reg(bsfb_pkg::CFG_FOOTER, ftr);
    write_reg(bsfb_pkg::CFG_ESCAPE, esc);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of random length, random gaps between them when pacing is on.
  task automatic send_payload(input octet_t b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (pace_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 2);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.final_byte   <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Payload values lean hard on the current special values and the extremes,
  // so escapes are frequent and back to back.
  function automatic octet_t pick_byte();
    case ($urandom_range(0, 9))
      0:       return cur_hdr;
      1:       return cur_ftr;
      2:       return cur_esc;
      3:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return octet_t'($urandom);
    endcase
  endfunction

  task automatic send_message(input int len, input bit closes);
    int k;
    for (k = 0; k < len; k++) send_payload(pick_byte(), closes && (k == len - 1));
    if (closes) msgs_sent++;
    if (len > bsfb_pkg::MaxPayloadDef) long_msgs++;
  endtask

  // Wait until every predicted frame item has come out, then let the block go
  // quiet. The first edge lets the checker's count catch up with the last item.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int used;
    int len;
    int long_len;

    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= bsfb_pkg::CFG_HEADER;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= '0;
    in_ch.final_byte   <= 1'b0;
    cur_hdr    = bsfb_pkg::HeaderRst;
    cur_ftr    = bsfb_pkg::FooterRst;
    cur_esc    = bsfb_pkg::EscapeRst;
    pace_on    = 1'b1;
    burst_left = 0;
    items_sent = 0;
    msgs_sent  = 0;
    long_msgs  = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, reset values: header ED, footer EE, escape E9 ---
    // a write to the unused index must leave all three registers alone
    write_reg(CFG_UNUSED, 8'h5A);
    cfg_we <= 1'b0;
    // single-item message with a zero payload
    send_payload(8'h00, 1'b1);
    // every special value once, plus the top value, then a plain closer
    send_payload(8'hFF, 1'b0);
    send_payload(8'hED, 1'b0);
    send_payload(8'hEE, 1'b0);
    send_payload(8'hE9, 1'b0);
    send_payload(8'h80, 1'b1);
    // escape bytes back to back, the last one closing the message
    send_payload(8'hE9, 1'b0);
    send_payload(8'hE9, 1'b0);
    send_payload(8'hE9, 1'b1);
    // a lone footer value as the whole payload
    send_payload(8'hEE, 1'b1);
    msgs_sent += 4;
    settle();

    // extremes: header 0, footer FF; payloads equal to both ends of the range
    apply_setting(8'h00, 8'hFF, 8'h80);
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h80, 1'b0);
    send_payload(8'h7F, 1'b1);
    msgs_sent += 2;
    settle();

    // --- random part: one register setting per phase ---
    for (ph = 0; ph < 6; ph++) begin
      long_len = 0;
      pace_on  = 1'b1;
      case (ph)
        0: begin
          // reversed extremes; a message that fills the store exactly
          apply_setting(8'hFF, 8'h00, 8'h01);
          long_len = bsfb_pkg::MaxPayloadDef;
        end
        1: apply_setting(octet_t'($urandom), octet_t'($urandom), octet_t'($urandom));
        2: begin
          // all three registers equal; one byte past capacity (final dropped);
          // no sender gaps in this phase
          apply_setting(8'h55, 8'h55, 8'h55);
          long_len = bsfb_pkg::MaxPayloadDef + 1;
          pace_on  = 1'b0;
        end
        3: apply_setting(octet_t'($urandom), octet_t'($urandom), octet_t'($urandom));
        4: begin
          // escape changes while a message is half taken: counts and sum keep
          // the old value, emission uses the new one; the same message then
          // runs well past capacity
          write_reg(bsfb_pkg::CFG_ESCAPE, octet_t'($urandom));
          cfg_we <= 1'b0;
          long_len = bsfb_pkg::MaxPayloadDef + 4;
        end
        default: apply_setting(bsfb_pkg::HeaderRst, bsfb_pkg::FooterRst,
                               bsfb_pkg::EscapeRst);
      endcase

      used = 0;
      if (long_len != 0) begin
        send_message(long_len, 1'b1);
        used += long_len;
      end
      while (used < PhaseBudget) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
        send_message(len, 1'b1);
        used += len;
      end

      // leave a message open across the next register change
      if (ph == 3) begin
        send_payload(cur_esc, 1'b0);
        send_payload(cur_hdr, 1'b0);
        send_payload(pick_byte(), 1'b0);
      end
      settle();
    end

    $display("Run covered %0d payload items in %0d messages, %0d of them past capacity.",
             items_sent, msgs_sent, long_msgs);
    $display("%0d frames predicted, %0d frame items compared.", frames, checked);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
